// File: rtl/core/sdt_pkg.sv
// Package for the 1D squared distance transform.
// Types, sizes and command/status structs shared by controller and datapath.
package sdt_pkg;

	localparam int LINE_MAX = 64;
	localparam int IDX_W    = 6;
	localparam int BND_W    = 7;
	localparam int COST_W   = 40;
	localparam int S2_W     = 32;
	localparam int SQ_W     = 12;
	localparam int PROD_W   = 44;
	localparam int LIFT_W   = 50;
	localparam int DEN_W    = 38;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_MAX - 1);
	localparam logic [S2_W-1:0]  S2_RESET = 32'd65536;

	typedef enum logic [3:0] {
		ST_LOAD, ST_B_RD, ST_B_MUL, ST_B_LIFT, ST_B_SEP, ST_B_DIV, ST_B_INC,
		ST_B_CMP, ST_E_RD, ST_E_CHK, ST_E_ORG, ST_E_MUL, ST_E_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_BRD, OP_BMUL, OP_BLIFT, OP_BFIRST, OP_BSEP,
		OP_BDIV, OP_BINC, OP_BPOP, OP_BPUSH, OP_EREAD, OP_ECOST, OP_EOUT,
		OP_EFLAG
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] q;
		logic [2:0]       shamt;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic seeded;
		logic lift_le;
		logic div_ge;
		logic b_le;
		logic bnd_le_q;
		logic out_busy;
	} sts_t;

endpackage

// File: rtl/core/sdt_datapath.sv
// Datapath: sample and envelope memories, multipliers, divider, output register.
// Depends on sdt_pkg.
module sdt_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sdt_pkg::cmd_t               cmd,
	input  logic [sdt_pkg::COST_W-1:0]  in_cost,
	input  logic                        in_unseeded,
	input  logic                        cfg_valid,
	input  logic [15:0]                 cfg_data,
	input  logic                        m_tready,
	output sdt_pkg::sts_t               sts,
	output logic                        m_tvalid,
	output logic [47:0]                 m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast
);

	logic [sdt_pkg::S2_W-1:0]   s2_q;
	logic [sdt_pkg::COST_W:0]   cost_mem [sdt_pkg::LINE_MAX];
	logic [sdt_pkg::COST_W:0]   cost_rd_q;
	logic [sdt_pkg::IDX_W-1:0]  env_org [sdt_pkg::LINE_MAX];
	logic [sdt_pkg::BND_W-1:0]  env_bnd [sdt_pkg::LINE_MAX];
	logic [sdt_pkg::LIFT_W-1:0] env_lift [sdt_pkg::LINE_MAX];
	logic [sdt_pkg::IDX_W-1:0]  org_rd_q;
	logic [sdt_pkg::BND_W-1:0]  bnd_rd_q;
	logic [sdt_pkg::LIFT_W-1:0] lift_rd_q;
	logic [sdt_pkg::SQ_W-1:0]   sq_q;
	logic [sdt_pkg::PROD_W-1:0] prod_q;
	logic [sdt_pkg::LIFT_W-1:0] lift_q;
	logic [sdt_pkg::LIFT_W-1:0] num_q;
	logic [sdt_pkg::DEN_W-1:0]  den_q;
	logic [5:0]                 quot_q;
	logic [sdt_pkg::BND_W-1:0]  bnd_q;
	logic [39:0]                dist_q;
	logic [5:0]                 pos_q;
	logic                       unreached_q;
	logic                       final_q;
	logic                       out_valid_q;

	logic [sdt_pkg::LIFT_W-1:0] lift_c;
	logic [sdt_pkg::IDX_W-1:0]  dist_idx;
	logic [sdt_pkg::IDX_W-1:0]  sq_in;
	logic [sdt_pkg::LIFT_W-1:0] den_sh;
	logic [sdt_pkg::LIFT_W-1:0] rnd_c;
	logic [39:0]                sat_c;
	logic [sdt_pkg::IDX_W-1:0]  cost_ra;
	logic                       out_load;

	// parabola value and helpers
	assign lift_c   = {2'b0, cost_rd_q[sdt_pkg::COST_W-1:0], 8'b0}
	                + {6'b0, prod_q};
	assign dist_idx = (cmd.q >= org_rd_q) ? cmd.q - org_rd_q : org_rd_q - cmd.q;
	assign sq_in    = (cmd.op == sdt_pkg::OP_BRD) ? cmd.q : dist_idx;
	assign den_sh   = {11'b0, den_q, 1'b0} << cmd.shamt;
	assign rnd_c    = lift_c + sdt_pkg::LIFT_W'(128);
	assign sat_c    = (|rnd_c[49:48]) ? '1 : rnd_c[47:8];
	assign cost_ra  = (cmd.op == sdt_pkg::OP_ECOST) ? org_rd_q : cmd.addr;
	assign out_load = (cmd.op == sdt_pkg::OP_EOUT) || (cmd.op == sdt_pkg::OP_EFLAG);

	// status back to the controller
	always_comb begin
		sts.seeded   = ~cost_rd_q[sdt_pkg::COST_W];
		sts.lift_le  = lift_q <= lift_rd_q;
		sts.div_ge   = num_q >= den_sh;
		sts.b_le     = bnd_q <= bnd_rd_q;
		sts.bnd_le_q = bnd_rd_q <= {1'b0, cmd.q};
		sts.out_busy = out_valid_q && !m_tready;
	end

	// step squared, updated on each config transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q <= sdt_pkg::S2_RESET;
		end else if (cfg_valid) begin
			s2_q <= cfg_data * cfg_data;
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.op == sdt_pkg::OP_LOAD) begin
			cost_mem[cmd.addr] <= {in_unseeded, in_cost};
		end
		if (cmd.op == sdt_pkg::OP_BRD || cmd.op == sdt_pkg::OP_ECOST) begin
			cost_rd_q <= cost_mem[cost_ra];
		end
	end

	// envelope store
	always_ff @(posedge clk) begin
		if (cmd.op == sdt_pkg::OP_BFIRST) begin
			env_org[0]  <= cmd.q;
			env_bnd[0]  <= '0;
			env_lift[0] <= lift_c;
		end else if (cmd.op == sdt_pkg::OP_BPUSH) begin
			env_org[cmd.addr]  <= cmd.q;
			env_bnd[cmd.addr]  <= bnd_q;
			env_lift[cmd.addr] <= lift_q;
		end
		if (cmd.op == sdt_pkg::OP_BLIFT || cmd.op == sdt_pkg::OP_BPOP ||
		    cmd.op == sdt_pkg::OP_EREAD) begin
			org_rd_q  <= env_org[cmd.addr];
			bnd_rd_q  <= env_bnd[cmd.addr];
			lift_rd_q <= env_lift[cmd.addr];
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			sdt_pkg::OP_BRD, sdt_pkg::OP_ECOST: begin
				sq_q <= sq_in * sq_in;
			end
			sdt_pkg::OP_BMUL: begin
				prod_q <= s2_q * sq_q;
			end
			sdt_pkg::OP_BLIFT, sdt_pkg::OP_BFIRST: begin
				lift_q <= lift_c;
			end
			sdt_pkg::OP_BSEP: begin
				num_q  <= lift_q - lift_rd_q - sdt_pkg::LIFT_W'(1);
				den_q  <= s2_q * (cmd.q - org_rd_q);
				quot_q <= '0;
				bnd_q  <= '0;
			end
			sdt_pkg::OP_BDIV: begin
				// restoring step; top step only detects the clamp
				if (num_q >= den_sh) begin
					if (cmd.shamt == 3'd6) begin
						bnd_q <= sdt_pkg::BND_W'(sdt_pkg::LINE_MAX);
					end else begin
						num_q <= num_q - den_sh;
						quot_q[cmd.shamt] <= 1'b1;
					end
				end
			end
			sdt_pkg::OP_BINC: begin
				bnd_q <= {1'b0, quot_q} + sdt_pkg::BND_W'(1);
			end
			default: begin
			end
		endcase
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			dist_q      <= (cmd.op == sdt_pkg::OP_EOUT) ? sat_c : '1;
			unreached_q <= (cmd.op == sdt_pkg::OP_EFLAG);
			pos_q       <= cmd.q;
			final_q     <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, pos_q, dist_q};
	assign m_tuser  = unreached_q;
	assign m_tlast  = final_q;

endmodule

// File: rtl/core/sdt_ctrl.sv
// Controller: sequences loading, envelope build and emission.
// Depends on sdt_pkg.
module sdt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	input  sdt_pkg::sts_t sts,
	output logic          s_tready,
	output sdt_pkg::cmd_t cmd
);

	sdt_pkg::state_t state_q, state_d;
	logic [sdt_pkg::IDX_W-1:0] cnt_q, cnt_d;
	logic [sdt_pkg::IDX_W-1:0] last_q, last_d;
	logic [sdt_pkg::IDX_W-1:0] q_q, q_d;
	logic [sdt_pkg::IDX_W-1:0] k_q, k_d;
	logic [sdt_pkg::IDX_W-1:0] top_q, top_d;
	logic [2:0]                sh_q, sh_d;
	logic                      any_q, any_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdt_pkg::ST_LOAD;
			cnt_q   <= '0;
			last_q  <= '0;
			q_q     <= '0;
			k_q     <= '0;
			top_q   <= '0;
			sh_q    <= '0;
			any_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
			q_q     <= q_d;
			k_q     <= k_d;
			top_q   <= top_d;
			sh_q    <= sh_d;
			any_q   <= any_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		last_d    = last_q;
		q_d       = q_q;
		k_d       = k_q;
		top_d     = top_q;
		sh_d      = sh_q;
		any_d     = any_q;
		s_tready  = 1'b0;
		cmd.op    = sdt_pkg::OP_NONE;
		cmd.addr  = '0;
		cmd.q     = q_q;
		cmd.shamt = sh_q;
		cmd.last  = (q_q == last_q);

		case (state_q)
			sdt_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				cmd.addr = cnt_q;
				if (s_tvalid) begin
					cmd.op = sdt_pkg::OP_LOAD;
					if (s_tlast || cnt_q == sdt_pkg::LAST_IDX) begin
						last_d  = cnt_q;
						cnt_d   = '0;
						q_d     = '0;
						any_d   = 1'b0;
						top_d   = '0;
						state_d = sdt_pkg::ST_B_RD;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			sdt_pkg::ST_B_RD: begin
				cmd.op   = sdt_pkg::OP_BRD;
				cmd.addr = q_q;
				state_d  = sdt_pkg::ST_B_MUL;
			end
			sdt_pkg::ST_B_MUL: begin
				cmd.op  = sdt_pkg::OP_BMUL;
				state_d = sdt_pkg::ST_B_LIFT;
			end
			sdt_pkg::ST_B_LIFT: begin
				if (sts.seeded && any_q) begin
					cmd.op   = sdt_pkg::OP_BLIFT;
					cmd.addr = top_q;
					state_d  = sdt_pkg::ST_B_SEP;
				end else begin
					if (sts.seeded) begin
						cmd.op = sdt_pkg::OP_BFIRST;
						any_d  = 1'b1;
						top_d  = '0;
					end
					if (q_q == last_q) begin
						q_d     = '0;
						k_d     = '0;
						state_d = sdt_pkg::ST_E_RD;
					end else begin
						q_d     = q_q + 1'b1;
						state_d = sdt_pkg::ST_B_RD;
					end
				end
			end
			sdt_pkg::ST_B_SEP: begin
				cmd.op = sdt_pkg::OP_BSEP;
				sh_d   = 3'd6;
				state_d = sts.lift_le ? sdt_pkg::ST_B_CMP : sdt_pkg::ST_B_DIV;
			end
			sdt_pkg::ST_B_DIV: begin
				cmd.op = sdt_pkg::OP_BDIV;
				if (sh_q == 3'd6 && sts.div_ge) begin
					state_d = sdt_pkg::ST_B_CMP;
				end else if (sh_q == 3'd0) begin
					state_d = sdt_pkg::ST_B_INC;
				end else begin
					sh_d = sh_q - 1'b1;
				end
			end
			sdt_pkg::ST_B_INC: begin
				cmd.op  = sdt_pkg::OP_BINC;
				state_d = sdt_pkg::ST_B_CMP;
			end
			sdt_pkg::ST_B_CMP: begin
				if (top_q != '0 && sts.b_le) begin
					cmd.op   = sdt_pkg::OP_BPOP;
					cmd.addr = top_q - 1'b1;
					top_d    = top_q - 1'b1;
					state_d  = sdt_pkg::ST_B_SEP;
				end else begin
					cmd.op   = sdt_pkg::OP_BPUSH;
					cmd.addr = top_q + 1'b1;
					top_d    = top_q + 1'b1;
					if (q_q == last_q) begin
						q_d     = '0;
						k_d     = '0;
						state_d = sdt_pkg::ST_E_RD;
					end else begin
						q_d     = q_q + 1'b1;
						state_d = sdt_pkg::ST_B_RD;
					end
				end
			end
			sdt_pkg::ST_E_RD: begin
				if (!any_q) begin
					state_d = sdt_pkg::ST_E_OUT;
				end else if (k_q < top_q) begin
					cmd.op   = sdt_pkg::OP_EREAD;
					cmd.addr = k_q + 1'b1;
					state_d  = sdt_pkg::ST_E_CHK;
				end else begin
					cmd.op   = sdt_pkg::OP_EREAD;
					cmd.addr = k_q;
					state_d  = sdt_pkg::ST_E_ORG;
				end
			end
			sdt_pkg::ST_E_CHK: begin
				// advance through boundaries already passed
				cmd.op = sdt_pkg::OP_EREAD;
				if (sts.bnd_le_q) begin
					k_d = k_q + 1'b1;
					if (k_q + 1'b1 < top_q) begin
						cmd.addr = k_q + 2'd2;
					end else begin
						cmd.addr = k_q + 1'b1;
						state_d  = sdt_pkg::ST_E_ORG;
					end
				end else begin
					cmd.addr = k_q;
					state_d  = sdt_pkg::ST_E_ORG;
				end
			end
			sdt_pkg::ST_E_ORG: begin
				cmd.op  = sdt_pkg::OP_ECOST;
				state_d = sdt_pkg::ST_E_MUL;
			end
			sdt_pkg::ST_E_MUL: begin
				cmd.op  = sdt_pkg::OP_BMUL;
				state_d = sdt_pkg::ST_E_OUT;
			end
			sdt_pkg::ST_E_OUT: begin
				if (!sts.out_busy) begin
					cmd.op = any_q ? sdt_pkg::OP_EOUT : sdt_pkg::OP_EFLAG;
					if (q_q == last_q) begin
						state_d = sdt_pkg::ST_LOAD;
					end else begin
						q_d     = q_q + 1'b1;
						state_d = sdt_pkg::ST_E_RD;
					end
				end
			end
			default: begin
				state_d = sdt_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

// File: rtl/core/squared_distance_transform_1d.sv
// Top level of the 1D squared distance transform (lower envelope of parabolas).
// Depends on sdt_pkg, sdt_ctrl and sdt_datapath.
//
// Samples load one per cycle; tlast, or the 64th sample, closes the line. The
// block then builds the parabola envelope: each sample is read and scaled and
// each seeded one lifted; an envelope comparison skips the divide when the new
// parabola is no worse anywhere, else runs a restoring divide (one step per
// cycle, 7 steps) whose top step only detects a crossing clamped at the line end.
// It then emits one result per sample in order, examining envelope boundaries as
// it goes (none when the line holds no seed) and waiting while the output is held
// off; the divider and the single envelope memory read port set the pace. Input
// is not taken during build and emission. sample_step is written on the cfg
// channel, which is always ready; write it only while idle.
module squared_distance_transform_1d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [39:0] cost
	input  logic        s_tuser,   // [0] unseeded
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [39:0] distance_sq, [45:40] position, zero above
	output logic        m_tuser,   // [0] unreached
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	sdt_pkg::cmd_t cmd;
	sdt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	sdt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_cost     (s_tdata),
		.in_unseeded (s_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.m_tready    (m_tready),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// File: dv/testbench.sv
// Self-checking testbench for squared_distance_transform_1d.
// Drives sample lines on the input stream and predicts the lower-envelope distances.
// Depends on sdt_pkg and the RTL top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [sdt_pkg::COST_W-1:0] cost;
		logic                       unseeded;
		logic                       line_end;
	} sample_t;

	typedef struct {
		logic [sdt_pkg::COST_W-1:0] distance_sq;
		logic                       unreached;
		logic [sdt_pkg::IDX_W-1:0]  position;
		logic                       final_sample;
	} dist_t;

	localparam longint unsigned SAT = 64'hFF_FFFF_FFFF;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	sample_t pending_samples[$];
	dist_t   expected_dist[$];
	sample_t nxt_sample;
	dist_t   got;
	dist_t   want;

	// predictor state: loaded line and current step
	logic [sdt_pkg::COST_W-1:0] line_cost[sdt_pkg::LINE_MAX];
	logic                       line_off[sdt_pkg::LINE_MAX];
	int                         line_count = 0;
	logic [15:0]                step_cur = 16'd256;

	int  snd_idle = 33;
	int  rcv_idle = 88;
	bit  hold_on = 0;
	bit  failed = 0;
	longint cycles = 0;
	event hold_start;

	squared_distance_transform_1d u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// parabola j evaluated at 0, i.e. its cost plus the s2*j^2 term, Q.8
	function automatic longint unsigned lifted(int j, longint unsigned s2);
		longint unsigned c;
		c = line_cost[j];
		return (c << 8) + s2 * longint'(j) * longint'(j);
	endfunction

	// first sample where parabola q is no worse than parabola p
	function automatic longint unsigned crossing(int p, int q, longint unsigned s2);
		longint unsigned fp, fq, den, b;
		fp = lifted(p, s2);
		fq = lifted(q, s2);
		if (fq <= fp)
			return 0;
		den = 2 * s2 * longint'(q - p);
		if (den == 0)
			return sdt_pkg::LINE_MAX;
		b = (fq - fp + den - 1) / den;
		return (b > sdt_pkg::LINE_MAX) ? sdt_pkg::LINE_MAX : b;
	endfunction

	// build the envelope over the closed line and queue one distance per sample
	function automatic void predict_line(int n);
		longint unsigned s2, b, v;
		int origin[sdt_pkg::LINE_MAX];
		longint unsigned bound[sdt_pkg::LINE_MAX+1];
		int top, k, p, d;
		bit any;
		dist_t r;
		s2 = longint'(step_cur) * longint'(step_cur);
		top = 0;
		any = 0;
		for (int q = 0; q < n; q++) begin
			if (line_off[q])
				continue;
			if (!any) begin
				origin[0] = q;
				bound[0] = 0;
				any = 1;
				continue;
			end
			forever begin
				b = crossing(origin[top], q, s2);
				if (top > 0 && b <= bound[top]) begin
					top--;
					continue;
				end
				top++;
				origin[top] = q;
				bound[top] = b;
				break;
			end
		end
		k = 0;
		for (int q = 0; q < n; q++) begin
			if (!any) begin
				r.distance_sq = SAT[39:0];
				r.unreached = 1;
			end else begin
				while (k < top && bound[k+1] <= q)
					k++;
				p = origin[k];
				d = (q >= p) ? q - p : p - q;
				v = (longint'(line_cost[p]) << 8) + s2 * longint'(d) * longint'(d);
				v = (v + 128) >> 8;
				r.distance_sq = (v > SAT) ? SAT[39:0] : v[39:0];
				r.unreached = 0;
			end
			r.position = q[sdt_pkg::IDX_W-1:0];
			r.final_sample = (q + 1 == n);
			expected_dist.push_back(r);
		end
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				line_cost[line_count] = s_tdata;
				line_off[line_count] = s_tuser;
				line_count++;
				if (s_tlast || line_count == sdt_pkg::LINE_MAX) begin
					predict_line(line_count);
					line_count = 0;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= snd_idle) begin
					nxt_sample = pending_samples.pop_front();
					s_tvalid <= 1;
					s_tdata <= nxt_sample.cost;
					s_tuser <= nxt_sample.unseeded;
					s_tlast <= nxt_sample.line_end;
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// long receiver stall, counted in cycles here
	initial begin
		forever begin
			@(hold_start);
			hold_on <= 1;
			repeat (500) @(posedge clk);
			hold_on <= 0;
		end
	end

	// result receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 0;
		else
			m_tready <= !hold_on && ($urandom_range(99) >= rcv_idle);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.distance_sq = m_tdata[39:0];
			got.position = m_tdata[45:40];
			got.unreached = m_tuser;
			got.final_sample = m_tlast;
			if (expected_dist.size() == 0) begin
				$error("unexpected result transaction, distance_sq %0h", got.distance_sq);
				failed = 1;
			end else begin
				want = expected_dist.pop_front();
				if (got.distance_sq !== want.distance_sq) begin
					$error("distance_sq expected %0h actual %0h",
						want.distance_sq, got.distance_sq);
					failed = 1;
				end
				if (got.unreached !== want.unreached) begin
					$error("unreached expected %0b actual %0b", want.unreached, got.unreached);
					failed = 1;
				end
				if (got.position !== want.position) begin
					$error("position expected %0d actual %0d", want.position, got.position);
					failed = 1;
				end
				if (got.final_sample !== want.final_sample) begin
					$error("final_sample expected %0b actual %0b",
						want.final_sample, got.final_sample);
					failed = 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_sample(input logic [39:0] c, input logic u, input logic l);
		sample_t s;
		s.cost = c;
		s.unseeded = u;
		s.line_end = l;
		pending_samples.push_back(s);
	endtask

	function automatic logic [39:0] rand_cost();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return 40'($urandom_range(30000));
		else if (sel == 6)
			return 40'h0;
		else if (sel == 7)
			return SAT[39:0];
		return 40'({$urandom, $urandom});
	endfunction

	// random line; full lines skip tlast and close on the size limit
	task automatic add_line(input int n, input int off_pct);
		for (int i = 0; i < n; i++)
			add_sample(rand_cost(), $urandom_range(99) < off_pct,
				(n < sdt_pkg::LINE_MAX) && (i == n - 1));
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || s_tvalid || expected_dist.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_step(input logic [15:0] v);
		wait_drained();
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		step_cur = v;
	endtask

	task automatic random_lines(input int count);
		for (int i = 0; i < count; i++)
			add_line($urandom_range(1, 12), ($urandom_range(9) == 0) ? 100 : 30);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset step, single sample, no seed, extremes, ties
		add_sample(40'd1000, 0, 1);
		add_sample(40'd5, 1, 0);
		add_sample(40'd7, 1, 1);
		add_sample(SAT[39:0], 0, 0);
		add_sample(40'h0, 0, 0);
		add_sample(SAT[39:0], 0, 1);
		add_sample(40'd256, 0, 0);
		add_sample(40'd0, 1, 0);
		add_sample(40'd256, 0, 1);
		wait_drained();
		write_step(16'hFFFF);
		add_sample(SAT[39:0], 0, 0);
		add_sample(40'd0, 1, 0);
		add_sample(40'd3, 0, 0);
		add_sample(40'd9, 1, 1);
		write_step(16'd0);
		add_sample(40'd500, 0, 0);
		add_sample(40'd200, 0, 0);
		add_sample(40'd900, 1, 0);
		add_sample(40'd200, 0, 1);
		write_step(16'd1);
		add_sample(40'd0, 0, 0);
		add_sample(40'd2, 0, 0);
		add_sample(40'd1, 0, 1);

		// random, sender idles little, receiver a lot
		write_step(16'd256);
		random_lines(4);
		add_line(sdt_pkg::LINE_MAX, 20);
		wait_drained();

		// long receiver hold while the sender keeps offering
		-> hold_start;
		random_lines(3);
		wait_drained();

		snd_idle = 88;
		rcv_idle = 33;
		write_step(16'($urandom_range(1, 65535)));
		random_lines(5);
		write_step(16'd1);
		random_lines(3);
		add_line(sdt_pkg::LINE_MAX, 50);

		snd_idle = 0;
		rcv_idle = 0;
		write_step(16'hFFFF);
		random_lines(2);
		write_step(16'($urandom_range(16, 2048)));
		random_lines(3);
		wait_drained();

		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: squared_distance_transform_1d.f
rtl/core/sdt_pkg.sv
rtl/core/sdt_datapath.sv
rtl/core/sdt_ctrl.sv
rtl/core/squared_distance_transform_1d.sv
dv/testbench.sv
